### rtl/core/olv_pkg.sv
// shared types and constants for the ordered value list
package olv_pkg;

    localparam int DEPTH         = 16;
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int VALUE_W       = 32;
    localparam int ENTRY_COUNT_W = 5;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [CNT_W-1:0]          t_count;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_UPDATE = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    // search token walking the cell chain
    typedef struct packed {
        logic active;
        logic found;
    } t_tok;

    // operation broadcast to every cell
    typedef struct packed {
        logic ins;
        logic upd;
        logic del;
    } t_cell_ctl;

endpackage

### rtl/core/olv_cell.sv
// one list slot: holds a value and its occupied bit, passes the search token on
module olv_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  olv_pkg::t_cell_ctl i_ctl,
    input  olv_pkg::t_value   i_match,
    input  olv_pkg::t_value   i_new,
    input  olv_pkg::t_value   i_prev_value,
    input  logic              i_prev_occ,
    input  olv_pkg::t_value   i_next_value,
    input  logic              i_next_occ,
    input  olv_pkg::t_tok     i_tok,
    output olv_pkg::t_tok     o_tok,
    output olv_pkg::t_value   o_value,
    output logic              o_occ
);

    olv_pkg::t_value r_value;
    olv_pkg::t_value n_value;
    logic            r_occ;
    logic            n_occ;
    olv_pkg::t_tok   r_tok;
    logic            w_hit;

    assign w_hit = r_occ && (r_value == i_match);

    always_comb begin
        n_value = r_value;
        n_occ   = r_occ;
        if (i_ctl.ins) begin
            // whole row moves one slot back
            n_value = i_prev_value;
            n_occ   = i_prev_occ;
        end else if (r_tok.active) begin
            if (i_ctl.upd && !r_tok.found && w_hit) begin
                n_value = i_new;
            end
            // from the first match onward every slot pulls in its successor
            if (i_ctl.del && (r_tok.found || w_hit)) begin
                n_value = i_next_value;
                n_occ   = i_next_occ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_tok <= '0;
        end else begin
            r_occ <= n_occ;
            r_tok <= i_tok;
        end
    end

    assign o_tok.active = r_tok.active;
    assign o_tok.found  = r_tok.found || (r_tok.active && w_hit);
    assign o_value      = r_value;
    assign o_occ        = r_occ;

endmodule

### rtl/core/ordered_value_list.sv
// top level: bounded newest-first list of signed values built as a chain of cells
//
// Requests enter on i_start while o_busy is low: i_func selects insert at
// front, update first match or delete first match, with i_match_value and
// i_new_value as operands. Each request gives exactly one result on o_status
// and o_entry_count, marked by o_valid for one cycle; the receiver cannot
// stall it.
// Insert shifts every cell at once: the result appears in the cycle after the
// transfer and a new request may follow in that same cycle.
// Update and delete send a search token down the chain of DEPTH cells, one
// cell per cycle; the token's walk sets the cost, so the result appears once
// the token has left the last cell, and o_busy stays high meanwhile.
// An unused function code returns status done with the list unchanged.
// Reset (synchronous, active low) empties the list and drops any request
// in flight; stored values need no clearing.
module ordered_value_list (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_func,
    input  logic signed [31:0] i_match_value,
    input  logic signed [31:0] i_new_value,
    output logic        o_busy,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [4:0]  o_entry_count
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic               r_state;
    logic               n_state;
    olv_pkg::t_count    r_count;
    olv_pkg::t_count    n_count;
    logic               r_valid;
    logic               n_valid;
    logic [1:0]         r_status;
    logic [1:0]         n_status;
    logic               r_upd;
    logic               r_del;
    olv_pkg::t_value    r_match;
    olv_pkg::t_value    r_new;

    logic               w_accept;
    olv_pkg::t_cell_ctl w_ctl;
    olv_pkg::t_tok      w_inject;

    olv_pkg::t_tok      w_tok    [olv_pkg::DEPTH];
    olv_pkg::t_value    w_value  [olv_pkg::DEPTH];
    logic               w_occ    [olv_pkg::DEPTH];
    logic [olv_pkg::DEPTH-1:0] w_tok_act;

    assign w_accept = i_start && (r_state == ST_IDLE);

    assign w_ctl.ins = w_accept && (i_func == olv_pkg::FUNC_INSERT)
                       && (r_count < olv_pkg::CNT_W'(olv_pkg::DEPTH));
    assign w_ctl.upd = r_upd;
    assign w_ctl.del = r_del;

    assign w_inject.active = w_accept && ((i_func == olv_pkg::FUNC_UPDATE)
                                          || (i_func == olv_pkg::FUNC_DELETE));
    assign w_inject.found  = 1'b0;

    genvar k;
    generate
        for (k = 0; k < olv_pkg::DEPTH; k++) begin : g_cell
            olv_pkg::t_tok   w_tok_in;
            olv_pkg::t_value w_prev_value;
            logic            w_prev_occ;
            olv_pkg::t_value w_next_value;
            logic            w_next_occ;

            if (k == 0) begin : g_head
                assign w_tok_in     = w_inject;
                assign w_prev_value = i_new_value;
                assign w_prev_occ   = 1'b1;
            end else begin : g_body
                assign w_tok_in     = w_tok[k-1];
                assign w_prev_value = w_value[k-1];
                assign w_prev_occ   = w_occ[k-1];
            end

            if (k == olv_pkg::DEPTH - 1) begin : g_tail
                assign w_next_value = '0;
                assign w_next_occ   = 1'b0;
            end else begin : g_mid
                assign w_next_value = w_value[k+1];
                assign w_next_occ   = w_occ[k+1];
            end

            olv_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_match      (r_match),
                .i_new        (r_new),
                .i_prev_value (w_prev_value),
                .i_prev_occ   (w_prev_occ),
                .i_next_value (w_next_value),
                .i_next_occ   (w_next_occ),
                .i_tok        (w_tok_in),
                .o_tok        (w_tok[k]),
                .o_value      (w_value[k]),
                .o_occ        (w_occ[k])
            );

            assign w_tok_act[k] = w_tok[k].active;
        end
    endgenerate

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_valid  = 1'b0;
        n_status = r_status;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_func)
                        olv_pkg::FUNC_INSERT: begin
                            n_valid = 1'b1;
                            if (w_ctl.ins) begin
                                n_status = olv_pkg::STATUS_DONE;
                                n_count  = r_count + 1'b1;
                            end else begin
                                n_status = olv_pkg::STATUS_FULL;
                            end
                        end
                        olv_pkg::FUNC_UPDATE, olv_pkg::FUNC_DELETE: begin
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_status = olv_pkg::STATUS_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // token leaving the last cell carries the search outcome
                if (w_tok[olv_pkg::DEPTH-1].active) begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                    if (w_tok[olv_pkg::DEPTH-1].found) begin
                        n_status = olv_pkg::STATUS_DONE;
                        if (r_del) begin
                            n_count = r_count - 1'b1;
                        end
                    end else begin
                        n_status = olv_pkg::STATUS_NOT_FOUND;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (w_accept) begin
            r_match <= i_match_value;
            r_new   <= i_new_value;
        end
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_upd   <= 1'b0;
            r_del   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            if (w_accept) begin
                r_upd <= (i_func == olv_pkg::FUNC_UPDATE);
                r_del <= (i_func == olv_pkg::FUNC_DELETE);
            end
        end
    end

    assign o_busy        = (r_state == ST_SCAN);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_entry_count = olv_pkg::ENTRY_COUNT_W'(r_count);

    // at most one search token in the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_act))
        else $error("more than one search token in the cell chain");

    // tokens only travel while a search is running
    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tok_act != '0) |-> (r_state == ST_SCAN))
        else $error("search token present outside a search");

    // count never exceeds the list depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= olv_pkg::CNT_W'(olv_pkg::DEPTH))
        else $error("entry count above depth");

    // a search request holds the block busy and gives no result next cycle
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && ((i_func == olv_pkg::FUNC_UPDATE)
                      || (i_func == olv_pkg::FUNC_DELETE)))
        |=> (o_busy && !o_valid))
        else $error("search request did not hold the block busy");

endmodule
